// ===== design/rspg_pkg.sv =====
// shared constants, types and the arctangent table of the ring and sphere point generator
package rspg_pkg;

  localparam int IndexBits    = 16;
  localparam int CountBits    = 16;
  localparam int RadiusBits   = 16;
  localparam int FracBits     = 32;
  localparam int DivW         = IndexBits + FracBits;
  localparam int RemW         = CountBits + 1;
  localparam int LatRingsLog2 = 3;
  localparam int PolBits      = LatRingsLog2 + 1;
  localparam int CordicStages = 16;
  localparam int AtanEntries  = 24;
  localparam int CordicRun    = (CordicStages < AtanEntries) ? CordicStages : AtanEntries;
  localparam int CordicW      = 34;
  localparam int TrigW        = 17;
  localparam int PosW         = 17;
  localparam int OutW         = 3 * PosW;
  localparam int OutBusW      = ((OutW + 7) / 8) * 8;
  localparam int CfgAddrW     = 2;

  localparam logic signed [CordicW-1:0] GainQ30 = 34'sd652032874;

  localparam logic [CfgAddrW-1:0] RegTotal  = 2'd0;
  localparam logic [CfgAddrW-1:0] RegRadius = 2'd1;
  localparam logic [CfgAddrW-1:0] RegMode   = 2'd2;

  localparam logic ModeRing   = 1'b0;
  localparam logic ModeSphere = 1'b1;

  typedef struct packed {
    logic signed [TrigW-1:0] s;
    logic signed [TrigW-1:0] c;
  } trig_t;

  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== design/rspg_div.sv =====
// pipelined restoring divider, one quotient bit per stage, index and turn fraction in one pass
module rspg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [rspg_pkg::IndexBits-1:0] idx_i,
  input  logic [rspg_pkg::CountBits-1:0] div_i,
  output logic                          valid_o,
  output logic [rspg_pkg::DivW-1:0]      quo_o
);

  logic                           v_q   [rspg_pkg::DivW];
  logic [rspg_pkg::RemW-1:0]      rem_q [rspg_pkg::DivW];
  logic [rspg_pkg::DivW-1:0]      sh_q  [rspg_pkg::DivW];

  for (genvar k = 0; k < rspg_pkg::DivW; k++) begin : g_stage
    logic                      v_in;
    logic [rspg_pkg::RemW-1:0] rem_in;
    logic [rspg_pkg::DivW-1:0] sh_in;
    logic [rspg_pkg::RemW-1:0] t;
    logic                      ge;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = '0;
      assign sh_in  = {idx_i, {rspg_pkg::FracBits{1'b0}}};
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign sh_in  = sh_q[k-1];
    end

    assign t  = {rem_in[rspg_pkg::RemW-2:0], sh_in[rspg_pkg::DivW-1]};
    assign ge = t >= {1'b0, div_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? (t - {1'b0, div_i}) : t;
        sh_q[k]  <= {sh_in[rspg_pkg::DivW-2:0], ge};
      end
    end
  end

  assign valid_o = v_q[rspg_pkg::DivW-1];
  assign quo_o   = sh_q[rspg_pkg::DivW-1];

endmodule

// ===== design/rspg_cordic.sv =====
// pipelined rotation cordic giving sine and cosine of a turn-fraction phase in signed Q2.15
module rspg_cordic (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [31:0]     phase_i,
  output logic            valid_o,
  output rspg_pkg::trig_t trig_o
);

  localparam int N = rspg_pkg::CordicRun;

  logic                                 v_q    [N+1];
  logic                                 flip_q [N+1];
  logic signed [rspg_pkg::CordicW-1:0]  x_q    [N+1];
  logic signed [rspg_pkg::CordicW-1:0]  y_q    [N+1];
  logic signed [rspg_pkg::CordicW-1:0]  z_q    [N+1];

  logic        flip;
  logic [31:0] ph;

  assign flip = phase_i[31] ^ phase_i[30];
  assign ph   = {phase_i[31] ^ flip, phase_i[30:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flip_q[0] <= flip;
      x_q[0]    <= rspg_pkg::GainQ30;
      y_q[0]    <= '0;
      z_q[0]    <= {{(rspg_pkg::CordicW-32){ph[31]}}, ph};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic signed [rspg_pkg::CordicW-1:0] Atan =
      {{(rspg_pkg::CordicW-32){1'b0}}, rspg_pkg::atan_turn(k)};
    logic signed [rspg_pkg::CordicW-1:0] xs;
    logic signed [rspg_pkg::CordicW-1:0] ys;
    logic                                pos;

    assign xs  = x_q[k] >>> k;
    assign ys  = y_q[k] >>> k;
    assign pos = !z_q[k][rspg_pkg::CordicW-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[k+1] <= flip_q[k];
        x_q[k+1]    <= pos ? (x_q[k] - ys) : (x_q[k] + ys);
        y_q[k+1]    <= pos ? (y_q[k] + xs) : (y_q[k] - xs);
        z_q[k+1]    <= pos ? (z_q[k] - Atan) : (z_q[k] + Atan);
      end
    end
  end

  logic signed [rspg_pkg::CordicW-1:0] xf, yf, xr, yr;
  logic signed [rspg_pkg::TrigW-1:0]   xc, yc;
  logic                                v_out_q;
  rspg_pkg::trig_t                     trig_q;

  assign xf = flip_q[N] ? -x_q[N] : x_q[N];
  assign yf = flip_q[N] ? -y_q[N] : y_q[N];
  assign xr = (xf + 34'sd16384) >>> 15;
  assign yr = (yf + 34'sd16384) >>> 15;

  always_comb begin
    if (xr > 34'sd32768) begin
      xc = 17'sd32768;
    end else if (xr < -34'sd32768) begin
      xc = -17'sd32768;
    end else begin
      xc = xr[rspg_pkg::TrigW-1:0];
    end
    if (yr > 34'sd32768) begin
      yc = 17'sd32768;
    end else if (yr < -34'sd32768) begin
      yc = -17'sd32768;
    end else begin
      yc = yr[rspg_pkg::TrigW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_out_q <= 1'b0;
    end else if (en_i) begin
      v_out_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_q.s <= yc;
      trig_q.c <= xc;
    end
  end

  assign valid_o = v_out_q;
  assign trig_o  = trig_q;

endmodule

// ===== design/rspg_scale.sv =====
// radius scaling: products, second product for the sphere, rounding to signed Q9.8
module rspg_scale (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic                            mode_i,
  input  logic [rspg_pkg::RadiusBits-1:0] radius_i,
  input  rspg_pkg::trig_t                 az_i,
  input  rspg_pkg::trig_t                 pol_i,
  output logic                            valid_o,
  output logic [rspg_pkg::PosW-1:0]       pos_x_o,
  output logic [rspg_pkg::PosW-1:0]       pos_y_o,
  output logic [rspg_pkg::PosW-1:0]       pos_z_o
);

  logic signed [rspg_pkg::RadiusBits:0] r_s;
  assign r_s = signed'({1'b0, radius_i});

  logic                          v1_q, v2_q, v3_q;
  logic signed [33:0]            pa1_q, pb1_q, pc1_q, pa2_q, pb2_q, pc2_q;
  logic signed [rspg_pkg::TrigW-1:0] sp1_q;
  logic signed [50:0]            qa2_q, qb2_q;
  logic [rspg_pkg::PosW-1:0]     x_q, y_q, z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa1_q <= r_s * az_i.c;
      pb1_q <= r_s * az_i.s;
      pc1_q <= r_s * pol_i.c;
      sp1_q <= pol_i.s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qa2_q <= pa1_q * sp1_q;
      qb2_q <= pb1_q * sp1_q;
      pa2_q <= pa1_q;
      pb2_q <= pb1_q;
      pc2_q <= pc1_q;
    end
  end

  logic signed [33:0] ra, rb, rc;
  logic signed [50:0] sa, sb;

  assign ra = (pa2_q + 34'sd16384) >>> 15;
  assign rb = (pb2_q + 34'sd16384) >>> 15;
  assign rc = (pc2_q + 34'sd16384) >>> 15;
  assign sa = (qa2_q + 51'sd536870912) >>> 30;
  assign sb = (qb2_q + 51'sd536870912) >>> 30;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (mode_i == rspg_pkg::ModeSphere) begin
        x_q <= sa[rspg_pkg::PosW-1:0];
        y_q <= rc[rspg_pkg::PosW-1:0];
        z_q <= sb[rspg_pkg::PosW-1:0];
      end else begin
        x_q <= ra[rspg_pkg::PosW-1:0];
        y_q <= '0;
        z_q <= rb[rspg_pkg::PosW-1:0];
      end
    end
  end

  assign valid_o = v3_q;
  assign pos_x_o = x_q;
  assign pos_y_o = y_q;
  assign pos_z_o = z_q;

endmodule

// ===== design/ring_sphere_point_generator.sv =====
// top level of the ring and uv sphere point generator
//
//  channel   direction  payload (low bit up)
//  s_axis    in         tdata: particle_index[15:0]
//  m_axis    out        tdata: pos_x[16:0], pos_y[16:0], pos_z[16:0], 5 zero bits
//  cfg       in         cfg_addr_i 0 total_count, 1 radius, 2 shape_mode
//
//  one item per cycle while the output is not stalled
//  most of the pipeline is the 48-stage divider, one quotient bit per stage
//  all stages advance together when the output register is empty or taken
//  a stalled output holds every stage, so nothing is lost or repeated
//  reset clears valid bits and sets total_count 1, radius 1.0, ring mode
module ring_sphere_point_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,  // particle_index
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rspg_pkg::OutBusW-1:0]      m_axis_tdata,  // pos_x, pos_y, pos_z
  input  logic                              cfg_we_i,
  input  logic [rspg_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [15:0]                       cfg_data_i
);

  logic [rspg_pkg::CountBits-1:0]  total_q;
  logic [rspg_pkg::RadiusBits-1:0] radius_q;
  logic                            mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= 16'd1;
      radius_q <= 16'd256;
      mode_q   <= rspg_pkg::ModeRing;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        rspg_pkg::RegTotal:  total_q  <= cfg_data_i;
        rspg_pkg::RegRadius: radius_q <= cfg_data_i;
        rspg_pkg::RegMode:   mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [rspg_pkg::CountBits-1:0] total_eff, sect, sect_eff, divisor;

  assign total_eff = (total_q == '0) ? 16'd1 : total_q;
  assign sect      = total_q >> rspg_pkg::LatRingsLog2;
  assign sect_eff  = (sect == '0) ? 16'd1 : sect;
  assign divisor   = (mode_q == rspg_pkg::ModeSphere) ? sect_eff : total_eff;

  logic adv;
  logic out_valid;
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;

  logic                       div_valid;
  logic [rspg_pkg::DivW-1:0]  quo;

  rspg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid),
    .idx_i   (s_axis_tdata[rspg_pkg::IndexBits-1:0]),
    .div_i   (divisor),
    .valid_o (div_valid),
    .quo_o   (quo)
  );

  logic [31:0] az_phase, pol_phase;
  assign az_phase  = quo[rspg_pkg::FracBits-1:0];
  assign pol_phase = {quo[rspg_pkg::FracBits+rspg_pkg::PolBits-1:rspg_pkg::FracBits],
                      {(rspg_pkg::FracBits-rspg_pkg::PolBits){1'b0}}};

  logic            az_valid, pol_valid;
  rspg_pkg::trig_t az_trig, pol_trig;

  rspg_cordic u_cordic_az (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (div_valid),
    .phase_i (az_phase),
    .valid_o (az_valid),
    .trig_o  (az_trig)
  );

  rspg_cordic u_cordic_pol (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (div_valid),
    .phase_i (pol_phase),
    .valid_o (pol_valid),
    .trig_o  (pol_trig)
  );

  logic [rspg_pkg::PosW-1:0] pos_x, pos_y, pos_z;

  rspg_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (az_valid && pol_valid),
    .mode_i   (mode_q),
    .radius_i (radius_q),
    .az_i     (az_trig),
    .pol_i    (pol_trig),
    .valid_o  (out_valid),
    .pos_x_o  (pos_x),
    .pos_y_o  (pos_y),
    .pos_z_o  (pos_z)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(rspg_pkg::OutBusW-rspg_pkg::OutW){1'b0}}, pos_z, pos_y, pos_x};

  logic signed [17:0] x_w, z_w, r_w;
  assign x_w = signed'({pos_x[16], pos_x});
  assign z_w = signed'({pos_z[16], pos_z});
  assign r_w = signed'({2'b00, radius_q});

  a_ring_y_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (mode_q == rspg_pkg::ModeRing) |-> pos_y == '0)
    else $error("y not zero in ring mode");

  a_x_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (x_w <= r_w) && (x_w >= -r_w))
    else $error("x beyond radius");

  a_z_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (z_w <= r_w) && (z_w >= -r_w))
    else $error("z beyond radius");

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the ring and uv sphere point generator: directed table, an unmapped register write, then random items
`timescale 1ns / 1ps

module tb_top;

  localparam logic [rspg_pkg::CfgAddrW-1:0] RegUnused = 2'd3;
  localparam int Latency = rspg_pkg::DivW + rspg_pkg::CordicRun + 5;
  localparam int CycleLimit = 400000;
  localparam int RandPhases = 10;
  localparam int PhaseItems = 85;

  typedef struct packed {
    logic signed [rspg_pkg::PosW-1:0] x;
    logic signed [rspg_pkg::PosW-1:0] y;
    logic signed [rspg_pkg::PosW-1:0] z;
  } point_t;

  typedef struct packed {
    logic [15:0] total;
    logic [15:0] rad;
    logic [15:0] mode_word;
    logic [15:0] idx;
    logic        typed;
    point_t      pos;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [rspg_pkg::OutBusW-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [rspg_pkg::CfgAddrW-1:0] cfg_addr_i = '0;
  logic [15:0] cfg_data_i = '0;

  logic [15:0] sh_total = 16'd1;
  logic [15:0] sh_radius = 16'd256;
  logic sh_mode = rspg_pkg::ModeRing;

  point_t pending_points[$];
  int errors = 0;
  int cycles = 0;
  int rx_stall = 0;
  bit rx_burst = 1'b0;
  bit tx_burst = 1'b0;

  ring_sphere_point_generator u_dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic longint round_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32768) r = 64'sd32768;
    if (r < -64'sd32768) r = -64'sd32768;
    return r;
  endfunction

  function automatic logic [31:0] turn_fraction(input longint unsigned num,
                                                input longint unsigned den);
    return 32'(((num % den) << 32) / den);
  endfunction

  task automatic cordic_sin_cos(input logic [31:0] phase, output longint s, output longint c);
    longint x, y, z, nx;
    bit flip;
    flip = (phase >= 32'h4000_0000) && (phase < 32'hC000_0000);
    if (flip) phase = phase + 32'h8000_0000;
    x = 64'sd652032874;
    y = 0;
    z = phase[31] ? longint'({32'd0, phase}) - 64'sd4294967296 : longint'({32'd0, phase});
    for (int i = 0; i < rspg_pkg::CordicRun; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'({32'd0, rspg_pkg::atan_turn(i)});
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'({32'd0, rspg_pkg::atan_turn(i)});
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = round_q15(x);
    s = round_q15(y);
  endtask

  task automatic predict_point(input logic [15:0] idx, output point_t p);
    longint unsigned tot, sectors;
    longint r, sa, ca, sp, cp;
    tot = (sh_total == 0) ? 1 : sh_total;
    r = longint'({48'd0, sh_radius});
    if (sh_mode == rspg_pkg::ModeRing) begin
      cordic_sin_cos(turn_fraction(idx, tot), sa, ca);
      p.x = rspg_pkg::PosW'((r * ca + 64'sd16384) >>> 15);
      p.y = '0;
      p.z = rspg_pkg::PosW'((r * sa + 64'sd16384) >>> 15);
    end else begin
      sectors = tot / 8;
      if (sectors == 0) sectors = 1;
      cordic_sin_cos(turn_fraction(idx % sectors, sectors), sa, ca);
      cordic_sin_cos(turn_fraction(idx / sectors, 16), sp, cp);
      p.x = rspg_pkg::PosW'((r * ca * sp + 64'sd536870912) >>> 30);
      p.y = rspg_pkg::PosW'((r * cp + 64'sd16384) >>> 15);
      p.z = rspg_pkg::PosW'((r * sa * sp + 64'sd536870912) >>> 30);
    end
  endtask

  task automatic report_mismatch(input string field,
                                 input logic signed [rspg_pkg::PosW-1:0] got,
                                 input logic signed [rspg_pkg::PosW-1:0] want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  // receiver: check accepted items, draw a stall after each
  always @(posedge clk_i) begin
    point_t got, want;
    int stall;
    stall = rx_stall;
    if (m_axis_tvalid && m_axis_tready) begin
      got.x = m_axis_tdata[rspg_pkg::PosW-1:0];
      got.y = m_axis_tdata[2*rspg_pkg::PosW-1:rspg_pkg::PosW];
      got.z = m_axis_tdata[3*rspg_pkg::PosW-1:2*rspg_pkg::PosW];
      if (pending_points.size() == 0) begin
        $display("unexpected item at cycle %0d", cycles);
        errors++;
      end else begin
        want = pending_points.pop_front();
        if (got.x !== want.x) report_mismatch("pos_x", got.x, want.x);
        if (got.y !== want.y) report_mismatch("pos_y", got.y, want.y);
        if (got.z !== want.z) report_mismatch("pos_z", got.z, want.z);
      end
      if ($urandom_range(0, 49) == 0) rx_burst = ~rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 19);
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall = stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
      rx_stall = 0;
    end
  end

  task automatic send_index(input logic [15:0] idx, input bit typed, input point_t typed_pos);
    int gap;
    point_t p;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= idx;
    do @(posedge clk_i); while (!s_axis_tready);
    if (typed) p = typed_pos;
    else predict_point(idx, p);
    pending_points.push_back(p);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rspg_pkg::CfgAddrW-1:0] addr, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (addr)
      rspg_pkg::RegTotal:  sh_total = val;
      rspg_pkg::RegRadius: sh_radius = val;
      rspg_pkg::RegMode:   sh_mode = val[0];
      default:   ;
    endcase
  endtask

  task automatic apply_config(input logic [15:0] total, input logic [15:0] rad,
                              input logic [15:0] mode_word);
    if (total == sh_total && rad == sh_radius && mode_word[0] == sh_mode) return;
    drain();
    write_reg(rspg_pkg::RegTotal, total);
    write_reg(rspg_pkg::RegRadius, rad);
    write_reg(rspg_pkg::RegMode, mode_word);
  endtask

  function automatic logic [15:0] pick_total();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd7;
      3: return 16'd65535;
      4, 5: return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_radius();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'd65535;
      2: return 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  row_t rows[] = '{
    '{16'd1, 16'd256, 16'd0, 16'd0, 1'b0, '0},
    '{16'd1, 16'd256, 16'd0, 16'd65535, 1'b0, '0},
    '{16'd1, 16'd0, 16'd0, 16'd1234, 1'b1, '0},
    '{16'd0, 16'd65535, 16'd0, 16'd0, 1'b0, '0},
    '{16'd0, 16'd65535, 16'd0, 16'd65535, 1'b0, '0},
    '{16'd65535, 16'd65535, 16'd0, 16'd16383, 1'b0, '0},
    '{16'd65535, 16'd65535, 16'd0, 16'd32767, 1'b0, '0},
    '{16'd65535, 16'd65535, 16'd0, 16'd49151, 1'b0, '0},
    '{16'd65535, 16'd65535, 16'd0, 16'd65534, 1'b0, '0},
    '{16'd65535, 16'd0, 16'd1, 16'd4444, 1'b1, '0},
    '{16'd7, 16'd256, 16'd1, 16'd3, 1'b0, '0},
    '{16'd8, 16'd65535, 16'd1, 16'd100, 1'b0, '0},
    '{16'd8, 16'd65535, 16'd1, 16'd15, 1'b0, '0},
    '{16'd65535, 16'd65535, 16'hFFFF, 16'd65535, 1'b0, '0},
    '{16'd65535, 16'd65535, 16'hFFFF, 16'd0, 1'b0, '0},
    '{16'd65535, 16'd65535, 16'hFFFE, 16'd8191, 1'b0, '0},
    '{16'd40, 16'd12345, 16'd1, 16'd21845, 1'b0, '0},
    '{16'd40, 16'd12345, 16'd1, 16'd43690, 1'b0, '0}
  };

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      apply_config(rows[i].total, rows[i].rad, rows[i].mode_word);
      send_index(rows[i].idx, rows[i].typed, rows[i].pos);
    end
    // writes to an unmapped index must leave the registers alone
    drain();
    write_reg(RegUnused, 16'hFFFF);
    send_index(16'd9999, 1'b0, '0);
    send_index(16'd1, 1'b0, '0);
    for (int ph = 0; ph < RandPhases; ph++) begin
      apply_config(pick_total(), pick_radius(), 16'($urandom));
      tx_burst = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 1) == 0)
          send_index(16'($urandom), 1'b0, '0);
        else
          send_index(16'($urandom_range(0, 2 * int'(sh_total) + 1)), 1'b0, '0);
      end
    end
    drain();
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== ring_sphere_point_generator.f =====
design/rspg_pkg.sv
design/rspg_div.sv
design/rspg_cordic.sv
design/rspg_scale.sv
design/ring_sphere_point_generator.sv
tb/sv/tb_top.sv
